### rtl/ba_pkg.sv
// Shared types and constants of the bump allocator.
package ba_pkg;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_INVALID  = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_OVERFLOW = 3'd3;
  localparam logic [2:0] ST_GROW     = 3'd4;
  localparam logic [2:0] ST_UNKNOWN  = 3'd5;
  localparam logic [2:0] ST_NOTFOUND = 3'd6;

  localparam logic [1:0] MODE_ALLOC   = 2'd0;
  localparam logic [1:0] MODE_FREE    = 2'd1;
  localparam logic [1:0] MODE_REALLOC = 2'd2;
  localparam logic [1:0] MODE_USABLE  = 2'd3;

  localparam logic CFG_INITIAL = 1'b0;
  localparam logic CFG_MAXPAGE = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CHECK,
    S_BUMP,
    S_GROW,
    S_RETIRE,
    S_DONE
  } state_t;

endpackage

### rtl/ba_table.sv
// Record table memory: offset and size per entry, one read and one write port.
module ba_table import ba_pkg::*; #(
  parameter int TABLE_DEPTH = 256,
  parameter int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic          clk,
  input  logic [IW-1:0] rd_index,
  output logic [31:0]   rd_offset,
  output logic [31:0]   rd_size,
  input  logic          wr_en,
  input  logic [IW-1:0] wr_index,
  input  logic [31:0]   wr_offset,
  input  logic [31:0]   wr_size
);

  logic [63:0] mem [TABLE_DEPTH];
  logic [63:0] rd_word;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_index] <= {wr_offset, wr_size};
    end
    rd_word <= mem[rd_index];
  end

  assign rd_offset = rd_word[63:32];
  assign rd_size   = rd_word[31:0];

endmodule

### rtl/bump_allocator_with_table.sv
// Top level of the bump allocator with its record table and control sequencer.
//
//   channel   direction  signals
//   request   in         valid, ready, mode, address, request_size, alignment
//   result    out        result_valid, result_ready, result_value, status,
//                        copy_needed, copy_from, copy_length
//   config    in         cfg_we, cfg_index, cfg_data
//
// One request is served at a time; ready is high only while idle. A request that needs
// neither table nor bump goes from S_READ straight to S_DONE, where result_valid is
// high; a valid alloc first passes S_BUMP and, with room, S_GROW. A table search in
// S_CHECK reads one entry per cycle through the registered read port until a hit or
// a miss at record_count, and a realloc that moves then bumps as an alloc and retires
// its old record in S_RETIRE when the bump succeeds. ready returns the cycle after the
// result is taken, and a stalled result simply holds the block in its final state.
// Reset is synchronous and clears the control state; the table needs no clearing
// since only entries below record_count are ever examined.
module bump_allocator_with_table import ba_pkg::*; #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        valid,
  output logic        ready,
  input  logic [1:0]  mode,
  input  logic [31:0] address,
  input  logic signed [31:0] request_size,
  input  logic signed [31:0] alignment,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [31:0] result_value,
  output logic [2:0]  status,
  output logic        copy_needed,
  output logic [31:0] copy_from,
  output logic [31:0] copy_length,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  // Configuration registers.
  logic [31:0] initial_bytes;
  logic [16:0] max_pages;

  // Allocator state.
  logic        started;
  logic [31:0] heap_top;
  logic [16:0] memory_pages;
  logic [CW-1:0] record_count;

  // Latched request.
  logic [1:0]  req_mode;
  logic [31:0] req_addr;
  logic [31:0] req_size;
  logic [31:0] req_align;

  // Sequencer and scan state.
  state_t        state, state_next;
  logic [CW-1:0] scan_idx;
  logic          scan_pending;
  logic [IW-1:0] found_idx;
  logic [31:0]   found_size;

  // Bump results carried from the address stage to the growth stage.
  logic [31:0] bump_at;
  logic [32:0] bump_end;

  // Table interface.
  logic [IW-1:0] rd_index;
  logic [31:0]   rd_offset, rd_size;
  logic          wr_en;
  logic [IW-1:0] wr_index;
  logic [31:0]   wr_offset, wr_size;

  ba_table #(.TABLE_DEPTH(TABLE_DEPTH), .IW(IW)) u_table (
    .clk       (clk),
    .rd_index  (rd_index),
    .rd_offset (rd_offset),
    .rd_size   (rd_size),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_offset (wr_offset),
    .wr_size   (wr_size)
  );

  // Request classification. The size is positive and the alignment a positive
  // power of two for a valid allocation.
  logic size_pos, align_good, is_search, is_alloc_like, do_realloc_path;
  logic [31:0] eff_align;
  assign size_pos   = !req_size[31] && (req_size != 32'd0);
  assign align_good = !req_align[31] && (req_align != 32'd0) &&
                      ((req_align & (req_align - 32'd1)) == 32'd0);
  // Alloc, or realloc of null.
  assign is_alloc_like = (req_mode == MODE_ALLOC) ||
                         (req_mode == MODE_REALLOC && req_addr == 32'd0);
  // Free, realloc and size query of a non-null address look the record up.
  assign is_search = !is_alloc_like && (req_addr != 32'd0);
  assign do_realloc_path = (req_mode == MODE_REALLOC) && !is_alloc_like;
  // A moving realloc falls back to 16-byte alignment when the one asked is bad.
  assign eff_align = (do_realloc_path && !align_good) ? 32'd16 : req_align;

  // Scan: the registered read port returns the entry addressed in the previous
  // cycle, which is scan_idx - 1 whenever scan_pending is set.
  logic          hit, scan_miss, hit_clears, hit_moves;
  logic [IW-1:0] hit_idx;
  assign rd_index   = scan_idx[IW-1:0];
  assign hit        = scan_pending && (rd_offset == req_addr) && (rd_size != 32'd0);
  assign scan_miss  = !hit && (scan_idx >= record_count);
  assign hit_idx    = scan_idx[IW-1:0] - 1'b1;
  assign hit_clears = (req_mode == MODE_FREE) ||
                      (req_mode == MODE_REALLOC && !size_pos);
  assign hit_moves  = (req_mode == MODE_REALLOC) && size_pos && (req_size > rd_size);

  // Bump arithmetic: aligned address and end in one stage, page growth in the next.
  logic [32:0] at_calc, end_calc, have_bytes, need_bytes;
  logic [17:0] pages_total;
  logic        grow_needed, grow_fail, no_room;
  assign at_calc  = ({1'b0, heap_top} + {1'b0, eff_align} - 33'd1) &
                    ~({1'b0, eff_align} - 33'd1);
  assign end_calc = at_calc + {1'b0, req_size};
  assign no_room  = (record_count >= CW'(TABLE_DEPTH)) || at_calc[32] || end_calc[32];
  assign have_bytes  = {memory_pages, 16'd0};
  assign need_bytes  = bump_end - have_bytes + 33'h0FFFF;
  assign pages_total = {1'b0, memory_pages} + {1'b0, need_bytes[32:16]};
  assign grow_needed = bump_end > have_bytes;
  assign grow_fail   = grow_needed && (pages_total > {1'b0, max_pages});

  // Heap start-up, applied on the first request other than a free of null.
  logic [32:0] init_top;
  logic        start_now;
  assign init_top  = ({1'b0, initial_bytes} + 33'd15) & ~33'd15;
  assign start_now = (state == S_READ) && !started &&
                     !(req_mode == MODE_FREE && req_addr == 32'd0);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (valid) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        if (is_search) begin
          state_next = S_CHECK;
        end else if (is_alloc_like && size_pos && align_good) begin
          state_next = S_BUMP;
        end else begin
          state_next = S_DONE;
        end
      end
      S_CHECK: begin
        if (hit) begin
          state_next = hit_moves ? S_BUMP : S_DONE;
        end else if (scan_miss) begin
          state_next = S_DONE;
        end
      end
      S_BUMP: begin
        state_next = no_room ? S_DONE : S_GROW;
      end
      S_GROW: begin
        state_next = (!grow_fail && do_realloc_path) ? S_RETIRE : S_DONE;
      end
      S_RETIRE: state_next = S_DONE;
      S_DONE: begin
        if (result_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Handshakes and the table write port. A freed record keeps its offset and
  // gets size zero; a new record is logged at index record_count.
  always_comb begin
    wr_en     = 1'b0;
    wr_index  = hit_idx;
    wr_offset = req_addr;
    wr_size   = 32'd0;
    unique case (state)
      S_CHECK: wr_en = hit && hit_clears;
      S_GROW: begin
        wr_en     = !grow_fail;
        wr_index  = record_count[IW-1:0];
        wr_offset = bump_at;
        wr_size   = req_size;
      end
      S_RETIRE: begin
        wr_en    = 1'b1;
        wr_index = found_idx;
      end
      default: ;
    endcase
  end

  assign ready        = (state == S_IDLE);
  assign result_valid = (state == S_DONE);

  // Control state and configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      initial_bytes <= 32'd65536;
      max_pages     <= 17'd65536;
      started       <= 1'b0;
      heap_top      <= 32'd0;
      memory_pages  <= 17'd0;
      record_count  <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_INITIAL: initial_bytes <= cfg_data;
          CFG_MAXPAGE: max_pages <= cfg_data[16:0];
          default: ;
        endcase
      end
      if (start_now) begin
        // Rounding up to 16 past 2^32 pins the top, so later allocations overflow.
        started      <= 1'b1;
        heap_top     <= init_top[32] ? 32'hFFFFFFFF : init_top[31:0];
        memory_pages <= {1'b0, initial_bytes[31:16]} +
                        {16'd0, initial_bytes[15:0] != 16'd0};
        record_count <= '0;
      end
      if (state == S_GROW && !grow_fail) begin
        if (grow_needed) begin
          memory_pages <= pages_total[16:0];
        end
        record_count <= record_count + 1'b1;
        heap_top     <= bump_end[31:0];
      end
    end
  end

  // Request, scan and result registers.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (valid) begin
          req_mode     <= mode;
          req_addr     <= address;
          req_size     <= request_size;
          req_align    <= alignment;
          result_value <= 32'd0;
          status       <= ST_OK;
          copy_needed  <= 1'b0;
          copy_from    <= 32'd0;
          copy_length  <= 32'd0;
          scan_idx     <= '0;
          scan_pending <= 1'b0;
        end
      end
      S_READ: begin
        if (is_alloc_like && !(size_pos && align_good)) begin
          status <= ST_INVALID;
        end
      end
      S_CHECK: begin
        if (hit) begin
          found_idx  <= hit_idx;
          found_size <= rd_size;
          if (req_mode == MODE_USABLE) begin
            result_value <= rd_size;
          end else if (req_mode == MODE_REALLOC && size_pos && !hit_moves) begin
            // The new size fits, so the block stays where it is.
            result_value <= req_addr;
          end
        end else if (scan_miss) begin
          status <= (req_mode == MODE_REALLOC) ? ST_UNKNOWN : ST_NOTFOUND;
        end else begin
          scan_idx     <= scan_idx + 1'b1;
          scan_pending <= 1'b1;
        end
      end
      S_BUMP: begin
        bump_at  <= at_calc[31:0];
        bump_end <= end_calc;
        if (record_count >= CW'(TABLE_DEPTH)) begin
          status <= ST_FULL;
        end else if (at_calc[32] || end_calc[32]) begin
          status <= ST_OVERFLOW;
        end
      end
      S_GROW: begin
        if (grow_fail) begin
          status <= ST_GROW;
        end else begin
          result_value <= bump_at;
          if (do_realloc_path) begin
            copy_needed <= 1'b1;
            copy_from   <= req_addr;
            copy_length <= found_size;
          end
        end
      end
      default: ;
    endcase
  end

endmodule
